### rtl/pmbg_pkg.sv
`default_nettype none

package pmbg_pkg;

    // operation codes on the command port
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MZ_LOW    = 3'd0;
    localparam logic [2:0] REG_MZ_HIGH   = 3'd1;
    localparam logic [2:0] REG_RT_LOW    = 3'd2;
    localparam logic [2:0] REG_RT_HIGH   = 3'd3;
    localparam logic [2:0] REG_MZ_SCALE  = 3'd4;
    localparam logic [2:0] REG_RT_SCALE  = 3'd5;
    localparam logic [2:0] REG_GRID_COLS = 3'd6;
    localparam logic [2:0] REG_GRID_ROWS = 3'd7;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage

`default_nettype wire

### rtl/pmbg_bin_calc.sv
`default_nettype none

module pmbg_bin_calc #(
    parameter int unsigned MAX = 64,
    localparam int unsigned IDX_W = $clog2(MAX)
) (
    input  wire logic                             clk,
    input  wire logic [pmbg_pkg::DATA_W-1:0]      value,
    input  wire logic [pmbg_pkg::DATA_W-1:0]      low,
    input  wire logic [pmbg_pkg::DATA_W-1:0]      high,
    input  wire logic [pmbg_pkg::DATA_W-1:0]      scale,
    input  wire logic [pmbg_pkg::COUNT_W-1:0]     count,
    output logic                                  win,
    output logic [IDX_W-1:0]                      idx,
    output logic [IDX_W-1:0]                      last
);

    localparam int unsigned LIM_W = $clog2(MAX + 1);
    localparam int unsigned CW    = (LIM_W > pmbg_pkg::COUNT_W) ? LIM_W : pmbg_pkg::COUNT_W;
    localparam int unsigned PW    = 2 * pmbg_pkg::DATA_W;

    logic [CW-1:0]                   count_ext;
    logic [CW-1:0]                   span;
    logic [CW-1:0]                   span_last;
    logic [pmbg_pkg::DATA_W-1:0]     off_reg;
    logic                            win_reg;
    logic [PW-1:0]                   prod_reg;
    logic [pmbg_pkg::DATA_W:0]       rounded;
    logic [IDX_W-1:0]                idx_reg;

    // cells in use: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        count_ext = CW'(count);
        if (count_ext == '0)
        begin
            span = CW'(1);
        end
        else if (count_ext > CW'(MAX))
        begin
            span = CW'(MAX);
        end
        else
        begin
            span = count_ext;
        end
        span_last = span - CW'(1);
    end

    assign last = span_last[IDX_W-1:0];

    // stage 1: window test and offset from the lower bound
    always_ff @(posedge clk)
    begin
        win_reg <= (value >= low) && (value <= high);
        off_reg <= value - low;
    end

    // stage 2: exact q32.32 product
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(off_reg) * PW'(scale);
    end

    // round half up, then saturate to the last cell
    assign rounded = {1'b0, prod_reg[PW-1:pmbg_pkg::DATA_W]}
                   + (pmbg_pkg::DATA_W + 1)'(prod_reg[pmbg_pkg::DATA_W-1]);

    always_ff @(posedge clk)
    begin
        if (rounded > (pmbg_pkg::DATA_W + 1)'(last))
        begin
            idx_reg <= last;
        end
        else
        begin
            idx_reg <= rounded[IDX_W-1:0];
        end
    end

    assign win = win_reg;
    assign idx = idx_reg;

endmodule

`default_nettype wire

### rtl/pmbg_store.sv
`default_nettype none

module pmbg_store #(
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                             clk,
    input  wire pmbg_pkg::mem_ctrl_t              ctrl,
    input  wire logic [ADDR_W-1:0]                addr,
    input  wire logic [pmbg_pkg::DATA_W-1:0]      wr_data,
    output logic [pmbg_pkg::DATA_W-1:0]           rd_data
);

    logic [pmbg_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### rtl/peak_max_binning_grid.sv
// peak max binning grid
//
// command channel: an item is taken at a clock edge with start high and
// busy low. operation selects clear store, accumulate peak or read cell.
// every accepted item gives exactly one result beat: done is high for one
// cycle with cell_value, in_window and cell_updated. the receiver cannot
// stall, so results are never held back.
// config port: cfg_write with cfg_index and cfg_data writes one register in
// the same edge; write only while busy is low and no result is pending.
// steps of each operation, from the accept edge to the done cycle:
//   accumulate  offset, product, round, memory read, update
//   read        memory read, result
//   unused op   result only
//   clear       one cell written per cycle over all MAX_COLS*MAX_ROWS cells
// a new item can be taken in the done cycle. the single-port grid memory
// and the three-stage bin pipeline set these steps.
// reset: config returns to the full window, unit scales and a 64 by 64
// grid, then a clearing sweep over all MAX_COLS*MAX_ROWS cells zeroes the
// store with busy high and no result beat.
`default_nettype none

module peak_max_binning_grid #(
    parameter int unsigned MAX_COLS = 64,
    parameter int unsigned MAX_ROWS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] peak_mz,
    input  wire logic [31:0] peak_rt,
    input  wire logic [31:0] peak_intensity,
    input  wire logic [5:0]  read_col,
    input  wire logic [5:0]  read_row,
    // result channel
    output logic             done,
    output logic [31:0]      cell_value,
    output logic             in_window,
    output logic             cell_updated,
    // configuration
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned COL_W  = $clog2(MAX_COLS);
    localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
    localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    // compare width for clamping the 6-bit read index
    localparam int unsigned RCW    = (COL_W > 6) ? COL_W : 6;
    localparam int unsigned RRW    = (ROW_W > 6) ? ROW_W : 6;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_OFFSET  = 7'b0000010,
        ST_PRODUCT = 7'b0000100,
        ST_ROUND   = 7'b0001000,
        ST_READ    = 7'b0010000,
        ST_UPDATE  = 7'b0100000,
        ST_CLEAR   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [31:0] mz_low_reg, mz_high_reg, rt_low_reg, rt_high_reg;
    logic [31:0] mz_scale_reg, rt_scale_reg;
    logic [6:0]  grid_cols_reg, grid_rows_reg;

    // captured command
    logic [1:0]  op_reg;
    logic [31:0] mz_reg, rt_reg, intensity_reg;
    logic [5:0]  read_col_reg, read_row_reg;

    // clear sweep
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_report_reg, clr_report_next;

    // result beat
    logic        done_reg, done_next;
    logic [31:0] value_reg, value_next;
    logic        win_out_reg, win_out_next;
    logic        upd_reg, upd_next;

    // bin units
    logic             mz_win, rt_win;
    logic [COL_W-1:0] col_idx, col_last;
    logic [ROW_W-1:0] row_idx, row_last;

    // memory side
    pmbg_pkg::mem_ctrl_t mem_ctrl;
    logic [ADDR_W-1:0]   mem_addr;
    logic [ADDR_W-1:0]   addr_reg;
    logic [31:0]         mem_wr_data;
    logic [31:0]         mem_rd_data;

    logic [RCW-1:0]   rc_sel;
    logic [RRW-1:0]   rr_sel;
    logic [COL_W-1:0] rd_col;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] sel_col;
    logic [ROW_W-1:0] sel_row;
    logic [ADDR_W-1:0] cell_addr;
    logic              peak_win;
    logic              peak_upd;

    pmbg_bin_calc #(
        .MAX (MAX_COLS)
    ) u_mz_bin (
        .clk   (clk),
        .value (mz_reg),
        .low   (mz_low_reg),
        .high  (mz_high_reg),
        .scale (mz_scale_reg),
        .count (grid_cols_reg),
        .win   (mz_win),
        .idx   (col_idx),
        .last  (col_last)
    );

    pmbg_bin_calc #(
        .MAX (MAX_ROWS)
    ) u_rt_bin (
        .clk   (clk),
        .value (rt_reg),
        .low   (rt_low_reg),
        .high  (rt_high_reg),
        .scale (rt_scale_reg),
        .count (grid_rows_reg),
        .win   (rt_win),
        .idx   (row_idx),
        .last  (row_last)
    );

    pmbg_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .ctrl    (mem_ctrl),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mz_low_reg    <= 32'h0000_0000;
            mz_high_reg   <= 32'hFFFF_FFFF;
            rt_low_reg    <= 32'h0000_0000;
            rt_high_reg   <= 32'hFFFF_FFFF;
            mz_scale_reg  <= 32'h0001_0000;
            rt_scale_reg  <= 32'h0001_0000;
            grid_cols_reg <= 7'd64;
            grid_rows_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pmbg_pkg::REG_MZ_LOW:    mz_low_reg    <= cfg_data;
                pmbg_pkg::REG_MZ_HIGH:   mz_high_reg   <= cfg_data;
                pmbg_pkg::REG_RT_LOW:    rt_low_reg    <= cfg_data;
                pmbg_pkg::REG_RT_HIGH:   rt_high_reg   <= cfg_data;
                pmbg_pkg::REG_MZ_SCALE:  mz_scale_reg  <= cfg_data;
                pmbg_pkg::REG_RT_SCALE:  rt_scale_reg  <= cfg_data;
                pmbg_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[6:0];
                pmbg_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data[6:0];
                default:                 ;
            endcase
        end
    end

    // command capture, held for the whole item
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg        <= operation;
            mz_reg        <= peak_mz;
            rt_reg        <= peak_rt;
            intensity_reg <= peak_intensity;
            read_col_reg  <= read_col;
            read_row_reg  <= read_row;
        end
    end

    // read index saturates to the last column / row in use
    always_comb
    begin
        if (RCW'(read_col_reg) > RCW'(col_last))
        begin
            rc_sel = RCW'(col_last);
        end
        else
        begin
            rc_sel = RCW'(read_col_reg);
        end
        if (RRW'(read_row_reg) > RRW'(row_last))
        begin
            rr_sel = RRW'(row_last);
        end
        else
        begin
            rr_sel = RRW'(read_row_reg);
        end
    end

    assign rd_col  = rc_sel[COL_W-1:0];
    assign rd_row  = rr_sel[ROW_W-1:0];
    assign sel_col = (op_reg == pmbg_pkg::OP_READ) ? rd_col : col_idx;
    assign sel_row = (op_reg == pmbg_pkg::OP_READ) ? rd_row : row_idx;

    // cell (col, row) sits at col + MAX_COLS * row
    assign cell_addr = ADDR_W'(sel_col)
                     + ADDR_W'(ADDR_W'(MAX_COLS) * ADDR_W'(sel_row));

    // read-modify-write; items do not overlap, so the write lands before
    // the next item's read and no forwarding is needed
    assign peak_win = (op_reg == pmbg_pkg::OP_ACCUM) && mz_win && rt_win;
    assign peak_upd = peak_win && (intensity_reg > mem_rd_data);

    always_comb
    begin
        mem_ctrl       = '0;
        mem_addr       = addr_reg;
        mem_wr_data    = intensity_reg;
        unique case (state_reg)
            ST_READ:
            begin
                mem_ctrl.rd_en = 1'b1;
                mem_addr       = cell_addr;
            end
            ST_UPDATE:
            begin
                mem_ctrl.wr_en = peak_upd;
            end
            ST_CLEAR:
            begin
                mem_ctrl.wr_en = 1'b1;
                mem_addr       = clr_cnt_reg;
                mem_wr_data    = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            addr_reg <= cell_addr;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        value_next      = value_reg;
        win_out_next    = win_out_reg;
        upd_next        = upd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        pmbg_pkg::OP_CLEAR:
                        begin
                            state_next      = ST_CLEAR;
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                        end
                        pmbg_pkg::OP_ACCUM: state_next = ST_OFFSET;
                        pmbg_pkg::OP_READ:  state_next = ST_READ;
                        default:            state_next = ST_UPDATE;
                    endcase
                end
            end
            ST_OFFSET:  state_next = ST_PRODUCT;
            ST_PRODUCT: state_next = ST_ROUND;
            ST_ROUND:   state_next = ST_READ;
            ST_READ:    state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                value_next   = (op_reg == pmbg_pkg::OP_READ) ? mem_rd_data : '0;
                win_out_next = peak_win;
                upd_next     = peak_upd;
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    // the sweep after reset gives no beat
                    state_next      = ST_IDLE;
                    done_next       = clr_report_reg;
                    clr_report_next = 1'b0;
                    value_next      = '0;
                    win_out_next    = 1'b0;
                    upd_next        = 1'b0;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        win_out_reg <= win_out_next;
        upd_reg     <= upd_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign cell_value   = value_reg;
    assign in_window    = win_out_reg;
    assign cell_updated = upd_reg;

endmodule

`default_nettype wire

### rtl/pmbg_checker.sv
`default_nettype none

module pmbg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] cell_value,
    input wire logic        in_window,
    input wire logic        cell_updated
);

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // a result beat only comes with the block idle, never twice in a row
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result beat while busy or repeated");

    // a cell is only replaced by a peak inside the window
    a_upd_win: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cell_updated) |-> in_window)
        else $error("cell updated outside window");

    // a nonzero value only comes from a read, which has no window flag
    a_value_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (cell_value != 32'd0)) |-> (!in_window && !cell_updated))
        else $error("nonzero value on an accumulate beat");

    // the clearing sweep runs right after reset
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("store not swept after reset");

endmodule

bind peak_max_binning_grid pmbg_checker u_checker (.*);

`default_nettype wire

### test/peak_max_binning_grid_tb.sv
`timescale 1ns / 100ps

module peak_max_binning_grid_tb;

    // grid geometry of the instance (default parameters)
    localparam int unsigned GRID_COLS_MAX = 64;
    localparam int unsigned GRID_ROWS_MAX = 64;
    localparam int unsigned GRID_CELLS    = GRID_COLS_MAX * GRID_ROWS_MAX;

    // a clear sweep accepts nothing and gives no beat while it runs, so the
    // watchdog allows several sweeps' worth of silence
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 115;

    // one command beat as presented on the command channel
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] mz;
        logic [31:0] rt;
        logic [31:0] inten;
        logic [5:0]  col;
        logic [5:0]  row;
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [31:0] value;
        logic        win;
        logic        upd;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = pmbg_pkg::OP_NONE;
    logic [31:0] peak_mz = '0;
    logic [31:0] peak_rt = '0;
    logic [31:0] peak_intensity = '0;
    logic [5:0]  read_col = '0;
    logic [5:0]  read_row = '0;
    logic        done;
    logic [31:0] cell_value;
    logic        in_window;
    logic        cell_updated;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = pmbg_pkg::REG_MZ_LOW;
    logic [31:0] cfg_data = '0;

    // commands waiting to be taken, and result beats still owed
    cmd_t  cmd_backlog[$];
    beat_t want_beats[$];
    cmd_t  seen_cmd;

    // our own copy of the grid store and the live configuration
    logic [31:0] grid_model [0:GRID_CELLS-1];
    logic [31:0] mz_lo_m, mz_hi_m, rt_lo_m, rt_hi_m, mz_scale_m, rt_scale_m;
    logic [6:0]  cols_m, rows_m;

    // register image loaded at the start of each phase
    logic [31:0] setup_regs [0:7];

    int idle_pct = 0;
    bit cmd_taken = 1'b0;
    int fail_count = 0;
    int quiet_cycles = 0;

    peak_max_binning_grid i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .peak_mz        (peak_mz),
        .peak_rt        (peak_rt),
        .peak_intensity (peak_intensity),
        .read_col       (read_col),
        .read_row       (read_row),
        .done           (done),
        .cell_value     (cell_value),
        .in_window      (in_window),
        .cell_updated   (cell_updated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // grid predictor
    // ------------------------------------------------------------------

    // size register to columns/rows in use: zero acts as one, too big saturates
    function automatic int unsigned span_used(logic [6:0] v, int unsigned lim);
        if (v == 7'd0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    // offset times reciprocal width, Q32.32 product, round half up, clamp
    function automatic int unsigned bin_of(logic [31:0] v, logic [31:0] lo,
                                           logic [31:0] scale, int unsigned n);
        logic [31:0] off;
        logic [63:0] prod;
        off  = v - lo;
        prod = {32'd0, off} * {32'd0, scale};
        prod = (prod + 64'h0000_0000_8000_0000) >> 32;
        bin_of = (prod > 64'(n - 1)) ? n - 1 : prod[31:0];
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            pmbg_pkg::REG_MZ_LOW:    mz_lo_m = data;
            pmbg_pkg::REG_MZ_HIGH:   mz_hi_m = data;
            pmbg_pkg::REG_RT_LOW:    rt_lo_m = data;
            pmbg_pkg::REG_RT_HIGH:   rt_hi_m = data;
            pmbg_pkg::REG_MZ_SCALE:  mz_scale_m = data;
            pmbg_pkg::REG_RT_SCALE:  rt_scale_m = data;
            pmbg_pkg::REG_GRID_COLS: cols_m = data[6:0];
            pmbg_pkg::REG_GRID_ROWS: rows_m = data[6:0];
            default: ;
        endcase
    endfunction

    // apply one command to the grid copy and give the beat it must produce
    function automatic beat_t run_command(cmd_t c);
        beat_t       b;
        int unsigned ncol, nrow, cx, ry;
        b    = '0;
        ncol = span_used(cols_m, GRID_COLS_MAX);
        nrow = span_used(rows_m, GRID_ROWS_MAX);
        case (c.op)
            pmbg_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < GRID_CELLS; i++)
                    grid_model[i] = '0;
            end
            pmbg_pkg::OP_ACCUM:
            begin
                // inclusive window; an empty window (low above high) rejects all
                if (c.mz >= mz_lo_m && c.mz <= mz_hi_m &&
                    c.rt >= rt_lo_m && c.rt <= rt_hi_m)
                begin
                    cx    = bin_of(c.mz, mz_lo_m, mz_scale_m, ncol);
                    ry    = bin_of(c.rt, rt_lo_m, rt_scale_m, nrow);
                    b.win = 1'b1;
                    // strictly greater replaces, cells keep fixed addresses
                    if (c.inten > grid_model[cx + GRID_COLS_MAX * ry])
                    begin
                        grid_model[cx + GRID_COLS_MAX * ry] = c.inten;
                        b.upd = 1'b1;
                    end
                end
            end
            pmbg_pkg::OP_READ:
            begin
                cx      = (c.col > ncol - 1) ? ncol - 1 : c.col;
                ry      = (c.row > nrow - 1) ? nrow - 1 : c.row;
                b.value = grid_model[cx + GRID_COLS_MAX * ry];
            end
            default: ;
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------
    // stimulus shaping
    // ------------------------------------------------------------------

    // coordinate mostly inside the window and near the grid, with edges,
    // one-outside values and raw noise mixed in
    function automatic logic [31:0] pick_coord(logic [31:0] lo, logic [31:0] hi,
                                               logic [31:0] scale, int unsigned n);
        logic [63:0] reach;
        logic [63:0] cap;
        logic [63:0] off;
        case ($urandom_range(0, 11))
            0: pick_coord = lo;
            1: pick_coord = hi;
            2: pick_coord = lo - 32'd1;
            3: pick_coord = hi + 32'd1;
            4: pick_coord = $urandom;
            default:
            begin
                if (lo > hi)
                    pick_coord = $urandom;
                else
                begin
                    // keep offsets within about two bins past the last bin in use
                    reach = {32'd0, hi - lo};
                    if (scale != 32'd0)
                    begin
                        cap = ((64'(n) + 64'd1) << 32) / {32'd0, scale};
                        if (cap < reach)
                            reach = cap;
                    end
                    off        = {$urandom, $urandom} % (reach + 64'd1);
                    pick_coord = lo + off[31:0];
                end
            end
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t        c;
        int unsigned r, ncol, nrow;
        ncol = span_used(cols_m, GRID_COLS_MAX);
        nrow = span_used(rows_m, GRID_ROWS_MAX);
        r    = $urandom_range(0, 99);
        // clears are rare since each one sweeps the whole store
        c.op = (r == 0)  ? pmbg_pkg::OP_CLEAR :
               (r <= 72) ? pmbg_pkg::OP_ACCUM :
               (r <= 95) ? pmbg_pkg::OP_READ  : pmbg_pkg::OP_NONE;
        c.mz = pick_coord(mz_lo_m, mz_hi_m, mz_scale_m, ncol);
        c.rt = pick_coord(rt_lo_m, rt_hi_m, rt_scale_m, nrow);
        case ($urandom_range(0, 9))
            0:          c.inten = '0;
            1:          c.inten = '1;
            2, 3, 4, 5: c.inten = $urandom;
            default:    c.inten = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            c.col = 6'($urandom);
            c.row = 6'($urandom);
        end
        else
        begin
            // cells in use plus one past the edge
            c.col = 6'($urandom_range(0, (ncol > 63) ? 63 : ncol));
            c.row = 6'($urandom_range(0, (nrow > 63) ? 63 : nrow));
        end
        return c;
    endfunction

    task automatic pick_window(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a, b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                lo = '0;
                hi = '1;
            end
            3, 4, 5:
            begin
                lo = a;
                hi = (a > 32'hFFEF_FFFF) ? 32'hFFFF_FFFF : a + $urandom_range(0, 32'h0010_0000);
            end
            6, 7:
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            8:
            begin
                // empty window
                lo = a | 32'd1;
                hi = $urandom_range(0, lo - 32'd1);
            end
            default:
            begin
                lo = a;
                hi = a;
            end
        endcase
    endtask

    function automatic logic [31:0] pick_scale(logic [31:0] lo, logic [31:0] hi,
                                               int unsigned n);
        logic [63:0] fit;
        case ($urandom_range(0, 9))
            0: pick_scale = '0;
            1: pick_scale = '1;
            2: pick_scale = 32'h0001_0000;
            3, 4, 5, 6:
            begin
                // spread the window over the grid
                if (hi <= lo)
                    pick_scale = 32'h0001_0000;
                else
                begin
                    fit        = (64'(n) << 32) / {32'd0, hi - lo};
                    pick_scale = (fit > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : fit[31:0];
                end
            end
            default: pick_scale = $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_count();
        case ($urandom_range(0, 9))
            0:       pick_count = 7'd0;
            1:       pick_count = 7'd1;
            2:       pick_count = 7'd2;
            3:       pick_count = 7'd64;
            4:       pick_count = 7'($urandom_range(65, 127));
            default: pick_count = 7'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] mz,
                            input logic [31:0] rt, input logic [31:0] inten,
                            input logic [5:0] col, input logic [5:0] row);
        cmd_t c;
        c.op    = op;
        c.mz    = mz;
        c.rt    = rt;
        c.inten = inten;
        c.col   = col;
        c.row   = row;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endtask

    // wait at a falling edge until every command is taken and answered
    task automatic drain();
        while (cmd_backlog.size() != 0 || want_beats.size() != 0 || busy)
            @(negedge clk);
    endtask

    // write the whole register image, one register per cycle
    task automatic load_setup();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= setup_regs[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // command driver: presents the oldest backlog entry at the falling edge,
    // holds it until taken, and idles at random per phase
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !cmd_taken)
            ;   // beat still offered, keep it steady
        else
        begin
            cmd_taken = 1'b0;
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start          <= 1'b1;
                operation      <= cmd_backlog[0].op;
                peak_mz        <= cmd_backlog[0].mz;
                peak_rt        <= cmd_backlog[0].rt;
                peak_intensity <= cmd_backlog[0].inten;
                read_col       <= cmd_backlog[0].col;
                read_row       <= cmd_backlog[0].row;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: result beats checked first (a command can be taken in the
    // done cycle), then config writes, then the command taken at this edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (done)
            begin
                quiet_cycles = 0;
                if (want_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    if (cell_value !== want_beats[0].value)
                    begin
                        $error("cell_value: expected %h, got %h", want_beats[0].value, cell_value);
                        fail_count++;
                    end
                    if (in_window !== want_beats[0].win)
                    begin
                        $error("in_window: expected %b, got %b", want_beats[0].win, in_window);
                        fail_count++;
                    end
                    if (cell_updated !== want_beats[0].upd)
                    begin
                        $error("cell_updated: expected %b, got %b", want_beats[0].upd,
                               cell_updated);
                        fail_count++;
                    end
                    want_beats.pop_front();
                end
            end
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (start && !busy)
            begin
                quiet_cycles = 0;
                seen_cmd = cmd_backlog.pop_front();
                want_beats.insert(want_beats.size(), run_command(seen_cmd));
                cmd_taken = 1'b1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("peak_max_binning_grid: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial
    begin
        logic [6:0]  ncols, nrows;
        logic [31:0] lo, hi, junk;

        // reset image of the predictor and of the register set
        for (int i = 0; i < GRID_CELLS; i++)
            grid_model[i] = '0;
        mz_lo_m    = '0;
        mz_hi_m    = '1;
        rt_lo_m    = '0;
        rt_hi_m    = '1;
        mz_scale_m = 32'h0001_0000;
        rt_scale_m = 32'h0001_0000;
        cols_m     = 7'd64;
        rows_m     = 7'd64;
        setup_regs[pmbg_pkg::REG_MZ_LOW]    = '0;
        setup_regs[pmbg_pkg::REG_MZ_HIGH]   = '1;
        setup_regs[pmbg_pkg::REG_RT_LOW]    = '0;
        setup_regs[pmbg_pkg::REG_RT_HIGH]   = '1;
        setup_regs[pmbg_pkg::REG_MZ_SCALE]  = 32'h0001_0000;
        setup_regs[pmbg_pkg::REG_RT_SCALE]  = 32'h0001_0000;
        setup_regs[pmbg_pkg::REG_GRID_COLS] = 32'd64;
        setup_regs[pmbg_pkg::REG_GRID_ROWS] = 32'd64;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the clearing sweep after reset holds busy high
        @(negedge clk);
        drain();

        // directed: reset window, unit scales, full 64 by 64 grid
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd0, 6'd0);
        push_cmd(pmbg_pkg::OP_ACCUM, '0, '0, '1, '0, '0);
        // just below half a bin rounds down, equal intensity keeps the cell
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0000_7FFF, '0, '1, '0, '0);
        // exactly half a bin rounds up
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0000_8000, 32'h0000_8000, 32'd7, '0, '0);
        // far corner clamps to the last column and row
        push_cmd(pmbg_pkg::OP_ACCUM, '1, '1, 32'd1, '0, '0);
        // zero intensity is inside the window but never replaces
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0005_0000, 32'h0003_0000, '0, '0, '0);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd63, 6'd63);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd0, 6'd0);
        // unused operation with every field bit high
        push_cmd(pmbg_pkg::OP_NONE,  '1, '1, '1, '1, '1);
        push_cmd(pmbg_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd1, 6'd1);
        drain();

        // point window in rt, extreme scales, zero columns and oversize rows
        setup_regs[pmbg_pkg::REG_MZ_LOW]    = 32'h0010_0000;
        setup_regs[pmbg_pkg::REG_MZ_HIGH]   = 32'h0020_0000;
        setup_regs[pmbg_pkg::REG_RT_LOW]    = 32'h0010_0000;
        setup_regs[pmbg_pkg::REG_RT_HIGH]   = 32'h0010_0000;
        setup_regs[pmbg_pkg::REG_MZ_SCALE]  = 32'hFFFF_FFFF;
        setup_regs[pmbg_pkg::REG_RT_SCALE]  = 32'h0000_0000;
        setup_regs[pmbg_pkg::REG_GRID_COLS] = 32'hFFFF_FF80;   // low bits zero: acts as one
        setup_regs[pmbg_pkg::REG_GRID_ROWS] = 32'h0000_007F;
        load_setup();
        idle_pct = 84;
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h000F_FFFF, 32'h0010_0000, 32'd3, '0, '0);
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0020_0001, 32'h0010_0000, 32'd3, '0, '0);
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0020_0000, 32'h0010_0000, 32'd9, '0, '0);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd63, 6'd63);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd5, 6'd0);
        drain();

        // two by two grid without a clear, empty mz window
        setup_regs[pmbg_pkg::REG_MZ_LOW]    = 32'h0030_0000;
        setup_regs[pmbg_pkg::REG_MZ_HIGH]   = 32'h0010_0000;
        setup_regs[pmbg_pkg::REG_GRID_COLS] = 32'd2;
        setup_regs[pmbg_pkg::REG_GRID_ROWS] = 32'd2;
        load_setup();
        idle_pct = 24;
        push_cmd(pmbg_pkg::OP_ACCUM, 32'h0020_0000, 32'h0010_0000, '1, '0, '0);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd0, 6'd0);
        push_cmd(pmbg_pkg::OP_READ,  '0, '0, '0, 6'd63, 6'd63);
        drain();

        // random phases, each with a fresh register set and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            ncols = pick_count();
            nrows = pick_count();
            pick_window(lo, hi);
            setup_regs[pmbg_pkg::REG_MZ_LOW]   = lo;
            setup_regs[pmbg_pkg::REG_MZ_HIGH]  = hi;
            setup_regs[pmbg_pkg::REG_MZ_SCALE] =
                pick_scale(lo, hi, span_used(ncols, GRID_COLS_MAX));
            pick_window(lo, hi);
            setup_regs[pmbg_pkg::REG_RT_LOW]   = lo;
            setup_regs[pmbg_pkg::REG_RT_HIGH]  = hi;
            setup_regs[pmbg_pkg::REG_RT_SCALE] =
                pick_scale(lo, hi, span_used(nrows, GRID_ROWS_MAX));
            // unused upper bits of the size registers get junk half the time
            junk = $urandom;
            setup_regs[pmbg_pkg::REG_GRID_COLS] = {junk[31:7] & {25{junk[0]}}, ncols};
            junk = $urandom;
            setup_regs[pmbg_pkg::REG_GRID_ROWS] = {junk[31:7] & {25{junk[0]}}, nrows};
            load_setup();
            // the result side cannot stall, so only the driver idles; even phases run without gaps
            case (p % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 84;
                2:       idle_pct = 0;
                default: idle_pct = 24;
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                cmd_backlog.insert(cmd_backlog.size(), rand_cmd());
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (20) @(negedge clk);
        if (fail_count == 0 && want_beats.size() == 0)
            $display("peak_max_binning_grid: match");
        else
            $display("peak_max_binning_grid: mismatch");
        $finish;
    end

endmodule
